@@ hw/rtl/brlm_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers for the block rms level meter
package brlm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_FRAMES_DEF = 256;
    localparam int QUEUE_DEPTH   = 2;
    localparam int LEVEL_W       = 15;
    localparam int SCALED_W      = 16;
    localparam int GAIN_W        = 16;
    localparam int SQ_W          = 29;
    localparam int MEAN_W        = 29;
    localparam int SMOOTH_W      = 24;
    localparam int SMOOTH_FRAC   = 9;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [SCALED_W-1:0]    FULL_ONE         = 16'd32768;
    localparam logic [GAIN_W-1:0]      GAIN_RESET       = 16'd4588;
    localparam logic [LEVEL_W-1:0]     FULL_SCALE_RESET = 15'd5571;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_GAIN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE     = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       last_frame;
    } frame_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  rms_level;
        logic [LEVEL_W-1:0]  smoothed_level;
        logic [SCALED_W-1:0] scaled_volume;
    } level_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  smoothing_gain;
        logic [LEVEL_W-1:0] full_scale_level;
    } cfg_t;

    // magnitude of a sample aligned to the 16-bit q1.15 scale
    function automatic logic [SAMPLE_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS-1:0] m;
        v = raw[SAMPLE_BITS-1:0];
        m = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
        return SAMPLE_W'(m) << (SAMPLE_W - SAMPLE_BITS);
    endfunction

endpackage

@@ hw/rtl/brlm_queue.sv @@
`timescale 1ns / 1ps
// short request queue between the accumulating front and the computing back
module brlm_queue
    import brlm_pkg::*;
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && count_reg == CNT_W'(DEPTH)) |-> pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");
`endif

endmodule

@@ hw/rtl/brlm_front.sv @@
`timescale 1ns / 1ps
// front: squares and accumulates frames, closes a buffer into the queue
module brlm_front
    import brlm_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int CNT_W      = $clog2(2 * MAX_FRAMES + 1),
    parameter int SUM_W      = SQ_W + $clog2(2 * MAX_FRAMES),
    parameter int QCNT_W     = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  frame_t                 frame,
    input  logic [QCNT_W-1:0]      q_count,
    output logic                   push,
    output logic [SUM_W+CNT_W-1:0] push_data
);

    localparam int LIMIT = 2 * MAX_FRAMES;

    logic                 accept;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_last_reg;
    logic [SQ_W-1:0]      s1_sq0_reg;
    logic [SQ_W-1:0]      s1_sq1_reg;
    logic [CNT_W-1:0]     s1_count_reg;

    logic                 en0, en1;
    logic [CNT_W:0]       c1, c2;
    logic [SAMPLE_W-1:0]  mag0, mag1;
    logic [2*SAMPLE_W-1:0] prod0, prod1;
    logic [SQ_W-1:0]      sq0, sq1;
    logic [SUM_W-1:0]     total;

    assign frame_stall = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg && s1_last_reg))
                         >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept = frame_valid && !frame_stall;

    // sample limit per buffer
    assign en0 = ((CNT_W+1)'(count_reg) < (CNT_W+1)'(LIMIT));
    assign c1  = (CNT_W+1)'(count_reg) + (CNT_W+1)'(en0);
    assign en1 = (c1 < (CNT_W+1)'(LIMIT));
    assign c2  = c1 + (CNT_W+1)'(en1);

    assign mag0  = sample_mag(frame.left_sample);
    assign mag1  = sample_mag(frame.right_sample);
    assign prod0 = mag0 * mag0;
    assign prod1 = mag1 * mag1;
    assign sq0   = prod0[SQ_W+1:2];
    assign sq1   = prod1[SQ_W+1:2];

    assign total = sum_reg + SUM_W'(s1_sq0_reg) + SUM_W'(s1_sq1_reg);
    assign push  = s1_valid_reg && s1_last_reg;
    assign push_data = {total, s1_count_reg};

    always_comb
    begin
        count_next    = count_reg;
        sum_next      = sum_reg;
        s1_valid_next = accept;
        if (accept)
        begin
            count_next = frame.last_frame ? '0 : c2[CNT_W-1:0];
        end
        if (s1_valid_reg)
        begin
            sum_next = s1_last_reg ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_last_reg <= frame.last_frame;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq0_reg   <= en0 ? sq0 : '0;
            s1_sq1_reg   <= en1 ? sq1 : '0;
            s1_count_reg <= c2[CNT_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W+1)'(count_reg) <= (CNT_W+1)'(LIMIT))
        else $error("sample count past buffer limit");
`endif

endmodule

@@ hw/rtl/brlm_back.sv @@
`timescale 1ns / 1ps
// back: mean, square root, smoothing and full-scale ratio per closed buffer
module brlm_back
    import brlm_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int CNT_W      = $clog2(2 * MAX_FRAMES + 1),
    parameter int SUM_W      = SQ_W + $clog2(2 * MAX_FRAMES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   q_empty,
    input  logic [SUM_W+CNT_W-1:0] q_data,
    output logic                   pop,
    output logic                   level_valid,
    input  logic                   level_stall,
    output level_t                 level
);

    localparam int R_W    = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int PROD_W = SMOOTH_W + GAIN_W + 1;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DIV_MEAN  = 4'd1;
    localparam logic [3:0] ST_SQRT      = 4'd2;
    localparam logic [3:0] ST_MUL_A     = 4'd3;
    localparam logic [3:0] ST_MUL_B     = 4'd4;
    localparam logic [3:0] ST_SMOOTH    = 4'd5;
    localparam logic [3:0] ST_LEVEL     = 4'd6;
    localparam logic [3:0] ST_DIV_SCALE = 4'd7;
    localparam logic [3:0] ST_DONE      = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [R_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [R_W-1:0]      divisor_reg, divisor_next;
    logic [MEAN_W-1:0]   x_reg, x_next;
    logic [MEAN_W:0]     res_reg, res_next;
    logic [MEAN_W-1:0]   sbit_reg, sbit_next;
    logic [LEVEL_W-1:0]  rms_reg, rms_next;
    logic [PROD_W-1:0]   prod_a_reg, prod_a_next;
    logic [PROD_W-1:0]   prod_b_reg, prod_b_next;
    logic [SMOOTH_W-1:0] smooth_reg, smooth_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                clamp_reg, clamp_next;
    logic                out_valid_reg, out_valid_next;
    level_t              out_data_reg, out_data_next;

    logic [SUM_W-1:0]    q_sum;
    logic [CNT_W-1:0]    q_cnt;
    logic [R_W:0]        rem_sh;
    logic                div_ge;
    logic [R_W:0]        rem_sub;
    logic [MEAN_W:0]     sq_try;
    logic                sq_ge;
    logic [MEAN_W:0]     x_sub;
    logic [GAIN_W:0]     gain_inv;
    logic [PROD_W-1:0]   prod_a_c, prod_b_c;
    logic [PROD_W:0]     smooth_sum;
    logic [SMOOTH_W:0]   level_sum;
    logic [SMOOTH_W-SMOOTH_FRAC:0] level_c;
    logic [LEVEL_W-1:0]  fs_eff;
    logic                scale_fits;
    logic                out_free;

    assign q_sum = q_data[SUM_W+CNT_W-1:CNT_W];
    assign q_cnt = q_data[CNT_W-1:0];
    assign pop   = (state_reg == ST_IDLE) && !q_empty;

    // shared restoring divider, one quotient bit a cycle
    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, divisor_reg});
    assign rem_sub = rem_sh - {1'b0, divisor_reg};

    // integer root, one result bit a cycle
    assign sq_try = res_reg + (MEAN_W+1)'(sbit_reg);
    assign sq_ge  = ({1'b0, x_reg} >= sq_try);
    assign x_sub  = {1'b0, x_reg} - sq_try;

    assign gain_inv   = (GAIN_W+1)'(1 << GAIN_W) - {1'b0, cfg.smoothing_gain};
    assign prod_a_c   = smooth_reg * gain_inv;
    assign prod_b_c   = {rms_reg, {SMOOTH_FRAC{1'b0}}} * cfg.smoothing_gain;
    assign smooth_sum = (PROD_W+1)'(prod_a_reg) + (PROD_W+1)'(prod_b_reg)
                        + (PROD_W+1)'(1 << (GAIN_W - 1));

    assign level_sum  = {1'b0, smooth_reg} + (SMOOTH_W+1)'(1 << (SMOOTH_FRAC - 1));
    assign level_c    = level_sum[SMOOTH_W:SMOOTH_FRAC];
    assign fs_eff     = (cfg.full_scale_level == '0) ? LEVEL_W'(1) : cfg.full_scale_level;
    assign scale_fits = (level_c < (SMOOTH_W-SMOOTH_FRAC+1)'(fs_eff));
    assign out_free   = !out_valid_reg || !level_stall;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        divisor_next   = divisor_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        sbit_next      = sbit_reg;
        rms_next       = rms_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        smooth_next    = smooth_reg;
        level_next     = level_reg;
        clamp_next     = clamp_reg;
        out_valid_next = out_valid_reg && level_stall;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    rem_next     = '0;
                    divisor_next = R_W'(q_cnt);
                    if (q_cnt == '0)
                    begin
                        quo_next  = '0;
                        step_next = '0;
                    end
                    else
                    begin
                        quo_next  = q_sum;
                        step_next = STEP_W'(SUM_W);
                    end
                    state_next = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN:
            begin
                if (step_reg == '0)
                begin
                    x_next     = quo_reg[MEAN_W-1:0];
                    res_next   = '0;
                    sbit_next  = MEAN_W'(1) << (MEAN_W - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    rem_next  = div_ge ? rem_sub[R_W-1:0] : rem_sh[R_W-1:0];
                    quo_next  = {quo_reg[SUM_W-2:0], div_ge};
                    step_next = step_reg - 1'b1;
                end
            end
            ST_SQRT:
            begin
                if (sbit_reg == '0)
                begin
                    rms_next   = res_reg[LEVEL_W-1:0];
                    state_next = ST_MUL_A;
                end
                else
                begin
                    if (sq_ge)
                    begin
                        x_next   = x_sub[MEAN_W-1:0];
                        res_next = (res_reg >> 1) + (MEAN_W+1)'(sbit_reg);
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    sbit_next = sbit_reg >> 2;
                end
            end
            ST_MUL_A:
            begin
                prod_a_next = prod_a_c;
                state_next  = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                prod_b_next = prod_b_c;
                state_next  = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                smooth_next = smooth_sum[GAIN_W+SMOOTH_W-1:GAIN_W];
                state_next  = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                level_next   = level_c[LEVEL_W-1:0];
                rem_next     = R_W'(level_c);
                quo_next     = '0;
                divisor_next = R_W'(fs_eff);
                clamp_next   = !scale_fits;
                step_next    = scale_fits ? STEP_W'(LEVEL_W) : '0;
                state_next   = ST_DIV_SCALE;
            end
            ST_DIV_SCALE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next  = div_ge ? rem_sub[R_W-1:0] : rem_sh[R_W-1:0];
                    quo_next  = {quo_reg[SUM_W-2:0], div_ge};
                    step_next = step_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.rms_level      = rms_reg;
                    out_data_next.smoothed_level = level_reg;
                    out_data_next.scaled_volume  = clamp_reg ? FULL_ONE
                                                   : {1'b0, quo_reg[LEVEL_W-1:0]};
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            smooth_reg    <= smooth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        divisor_reg  <= divisor_next;
        x_reg        <= x_next;
        res_reg      <= res_next;
        sbit_reg     <= sbit_next;
        rms_reg      <= rms_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        level_reg    <= level_next;
        clamp_reg    <= clamp_next;
        out_data_reg <= out_data_next;
    end

    assign level_valid = out_valid_reg;
    assign level       = out_data_reg;

`ifndef SYNTHESIS
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_DIV_MEAN))
        else $error("request taken without starting the mean");
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.rms_level <= 15'd16384
                           && out_data_reg.smoothed_level <= 15'd16384
                           && out_data_reg.scaled_volume <= FULL_ONE))
        else $error("result out of range");
`endif

endmodule

@@ hw/rtl/block_rms_level_meter.sv @@
`timescale 1ns / 1ps
// top level of the block rms level meter with exponential smoothing
//
//   channel   dir   valid         stall         payload
//   frame     in    frame_valid   frame_stall   frame_t  (left, right, last_frame)
//   level     out   level_valid   level_stall   level_t  (rms, smoothed, scaled)
//   cfg       in    cfg_write_en  -             cfg_index, cfg_data
//
// frames are taken one per cycle unless frame_stall is high; squares are registered
// and summed in the following cycle; a last frame hands its buffer to a two-entry
// queue; the back takes one buffer at a time through its one-bit-per-cycle divider
// and root
// reset clears the sum, the count, the smoothed level and the registers to defaults
// frame_stall rises while the queue and a closing buffer in flight fill it; a held
// result on level stops the back after it finishes its next buffer
module block_rms_level_meter
    import brlm_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  frame_t                 frame,
    output logic                   level_valid,
    input  logic                   level_stall,
    output level_t                 level,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W  = $clog2(2 * MAX_FRAMES + 1);
    localparam int SUM_W  = SQ_W + $clog2(2 * MAX_FRAMES);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t                   cfg_reg, cfg_next;
    logic                   push;
    logic [SUM_W+CNT_W-1:0] push_data;
    logic                   pop;
    logic [SUM_W+CNT_W-1:0] pop_data;
    logic                   q_empty;
    logic [QCNT_W-1:0]      q_count;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_SMOOTHING_GAIN: cfg_next.smoothing_gain   = cfg_data;
                REG_FULL_SCALE:     cfg_next.full_scale_level = cfg_data[LEVEL_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_gain   <= GAIN_RESET;
            cfg_reg.full_scale_level <= FULL_SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brlm_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W),
        .QCNT_W     (QCNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .q_count     (q_count),
        .push        (push),
        .push_data   (push_data)
    );

    brlm_queue #(
        .WIDTH (SUM_W + CNT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    brlm_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .level_valid (level_valid),
        .level_stall (level_stall),
        .level       (level)
    );

endmodule

@@ test/tb_block_rms_level_meter.sv @@
`timescale 1ns / 1ps
// self-checking testbench for block_rms_level_meter: directed table, then random buffers
module tb_block_rms_level_meter;
    import brlm_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left_s;
        logic signed [SAMPLE_W-1:0] right_s;
        logic                       last;
        bit                         typed;
        level_t                     want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   frame_valid = 1'b0;
    logic                   frame_stall;
    frame_t                 frame = '0;
    logic                   level_valid;
    logic                   level_stall = 1'b0;
    level_t                 level;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    level_t      pending_levels[$];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    logic [37:0]       energy_sum = '0;
    logic [9:0]        energy_count = '0;
    logic [23:0]       smooth_q24 = '0;
    logic [GAIN_W-1:0] gain_q16 = GAIN_RESET;
    logic [LEVEL_W-1:0] full_scale = FULL_SCALE_RESET;

    block_rms_level_meter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .level_valid  (level_valid),
        .level_stall  (level_stall),
        .level        (level),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd30_000_000);
        $display("** block_rms_level_meter: FAILED **");
        $finish;
    end

    function automatic logic [15:0] floor_sqrt(input logic [63:0] x);
        logic [15:0] r;
        logic [15:0] t;
        int          b;
        r = '0;
        for (b = 15; b >= 0; b--)
        begin
            t = r | (16'd1 << b);
            if (64'(t) * 64'(t) <= x)
                r = t;
        end
        return r;
    endfunction

    task automatic add_sample(input logic signed [SAMPLE_W-1:0] s);
        logic [15:0] mag;
        logic [31:0] sq;
        if (energy_count < 10'(2 * MAX_FRAMES_DEF))
        begin
            mag = s[15] ? (~s + 16'd1) : s;
            sq = 32'(mag) * 32'(mag);
            energy_sum = energy_sum + 38'(sq >> 2);
            energy_count = energy_count + 10'd1;
        end
    endtask

    task automatic close_buffer(output level_t lv);
        logic [63:0]        mean;
        logic [63:0]        acc;
        logic [15:0]        rms;
        logic [15:0]        lvl;
        logic [31:0]        scaled;
        logic [LEVEL_W-1:0] fs;
        mean = (energy_count != 0) ? 64'(energy_sum) / 64'(energy_count) : 64'd0;
        rms = floor_sqrt(mean);
        acc = (64'(smooth_q24) * (64'd65536 - 64'(gain_q16))
              + (64'(rms) << SMOOTH_FRAC) * 64'(gain_q16) + 64'd32768) >> 16;
        smooth_q24 = acc[23:0];
        lvl = 16'((64'(smooth_q24) + 64'd256) >> SMOOTH_FRAC);
        fs = (full_scale == 0) ? 15'd1 : full_scale;
        scaled = (32'(lvl) * 32'd32768) / 32'(fs);
        if (scaled > 32'd32768)
            scaled = 32'd32768;
        lv.rms_level = rms[14:0];
        lv.smoothed_level = lvl[14:0];
        lv.scaled_volume = scaled[15:0];
        energy_sum = '0;
        energy_count = '0;
    endtask

    task automatic send_frame(input frame_t f, input bit typed, input level_t want);
        level_t lv;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame <= f;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        add_sample(f.left_sample);
        add_sample(f.right_sample);
        if (f.last_frame)
        begin
            close_buffer(lv);
            pending_levels.insert(pending_levels.size(), typed ? want : lv);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_SMOOTHING_GAIN)
            gain_q16 = val;
        else
            full_scale = val[14:0];
    endtask

    task automatic settle();
        frame_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int shift);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 16'sh8000;
        if (r < 12)
            return 16'sh7FFF;
        if (r < 15)
            return 16'sh0000;
        if (r < 18)
            return 16'shFFFF;
        return $signed(16'($urandom)) >>> shift;
    endfunction

    task automatic run_phase(input logic [15:0] gain, input logic [14:0] fs, input int idle,
                             input int stall, input int n_items, input bit pause_mid);
        int     sent;
        int     len;
        int     r;
        int     shift;
        int     i;
        frame_t f;
        level_t none;
        settle();
        write_reg(REG_SMOOTHING_GAIN, gain);
        write_reg(REG_FULL_SCALE, 16'(fs));
        idle_pct = idle;
        stall_pct = stall;
        none = '0;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 3)
                len = $urandom_range(300, 250);
            else if (r < 25)
                len = 1;
            else
                len = $urandom_range(12, 2);
            shift = $urandom_range(15, 0);
            for (i = 0; i < len; i++)
            begin
                f.left_sample = pick_sample(shift);
                f.right_sample = pick_sample(shift);
                f.last_frame = (i == len - 1);
                send_frame(f, 1'b0, none);
            end
            sent += len;
            if (pause_mid && sent >= n_items / 2)
            begin
                // hold off until the back has drained
                frame_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_levels.size() != 0);
                pause_mid = 1'b0;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            level_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : level_check
        level_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && level_valid && !level_stall)
            begin
                if (pending_levels.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected level request rms=%0d smoothed=%0d scaled=%0d",
                             $time, level.rms_level, level.smoothed_level,
                             level.scaled_volume);
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (level.rms_level !== want.rms_level
                        || level.smoothed_level !== want.smoothed_level
                        || level.scaled_volume !== want.scaled_volume)
                    begin
                        errors++;
                        $display("%0t: level mismatch expected rms=%0d smoothed=%0d scaled=%0d",
                                 $time, want.rms_level, want.smoothed_level,
                                 want.scaled_volume);
                        $display("%0t:                actual rms=%0d smoothed=%0d scaled=%0d",
                                 $time, level.rms_level, level.smoothed_level,
                                 level.scaled_volume);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t rows[$];
        frame_t    f;
        int        k;
        rows = '{
            '{16'sh0000, 16'sh0000, 1'b1, 1'b1, '{15'd0, 15'd0, 16'd0}},
            '{16'sh8000, 16'sh8000, 1'b1, 1'b1, '{15'd16384, 15'd1147, 16'd6746}},
            '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, '0},
            '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '0},
            '{16'shFFFF, 16'sh0001, 1'b1, 1'b0, '0},
            '{16'sh5555, 16'shAAAA, 1'b0, 1'b0, '0},
            '{16'shAAAA, 16'sh5555, 1'b1, 1'b0, '0},
            '{16'sh0001, 16'shFFFF, 1'b1, 1'b0, '0},
            '{16'sh0064, 16'shFF38, 1'b0, 1'b0, '0},
            '{16'sh8AD0, 16'sh3039, 1'b0, 1'b0, '0},
            '{16'sh0007, 16'shFFF9, 1'b1, 1'b0, '0},
            '{16'sh0000, 16'sh0000, 1'b1, 1'b0, '0},
            '{16'sh0000, 16'sh0000, 1'b1, 1'b0, '0},
            '{16'sh4000, 16'shC000, 1'b1, 1'b0, '0}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (k = 0; k < rows.size(); k++)
        begin
            f.left_sample = rows[k].left_s;
            f.right_sample = rows[k].right_s;
            f.last_frame = rows[k].last;
            send_frame(f, rows[k].typed, rows[k].want);
        end
        run_phase(16'hFFFF, 15'd1, 0, 0, 250, 1'b0);
        run_phase(16'h0000, 15'd32767, 82, 0, 250, 1'b1);
        run_phase(16'($urandom), 15'($urandom_range(32767, 1)), 0, 82, 250, 1'b0);
        run_phase(16'($urandom), 15'($urandom_range(32767, 1)), 27, 27, 250, 1'b0);
        run_phase(16'd20000, 15'd2000, 0, 0, 250, 1'b0);
        settle();
        if (errors == 0)
            $display("** block_rms_level_meter: PASSED **");
        else
            $display("** block_rms_level_meter: FAILED **");
        $finish;
    end

endmodule
